// File: design/scd_pkg.sv
// Shared types and constants for the scan code set 2 decoder.
// Used by scd_ctrl, scd_datapath and the top level; depends on nothing.
package scd_pkg;

   // default number of held-key slots
   localparam int DEF_TABLE_SLOTS = 8;

   localparam int KEY_W = 16;

   // special keyboard bytes
   localparam logic [7:0] BYTE_SELF_TEST = 8'hAA;
   localparam logic [7:0] BYTE_BREAK     = 8'hF0;
   localparam logic [7:0] BYTE_EXTEND    = 8'hE0;
   localparam logic [7:0] BYTE_PAUSE     = 8'hE1;
   localparam logic [7:0] BYTE_CTRL      = 8'h14;
   localparam logic [7:0] BYTE_NUMLOCK   = 8'h77;

   // extended key codes carry E0 in the upper byte
   localparam logic [KEY_W-1:0] EXT_KEY_BASE = 16'hE000;

   // decode states
   localparam logic [3:0] DS_IDLE        = 4'd0;
   localparam logic [3:0] DS_EXT         = 4'd1;
   localparam logic [3:0] DS_BRK         = 4'd2;
   localparam logic [3:0] DS_EXT_BRK     = 4'd3;
   localparam logic [3:0] DS_PAUSE_FIRST = 4'd4;
   localparam logic [3:0] DS_PAUSE_LAST  = 4'd10;

   // sticky flag bit positions
   localparam int FLAG_SELF_TEST = 0;
   localparam int FLAG_PROTO     = 1;
   localparam int FLAG_PAUSE     = 2;
   localparam int FLAG_ROLLOVER  = 3;

   typedef enum logic [3:0] {
      EV_PREFIX   = 4'd0,
      EV_ADDED    = 4'd1,
      EV_HELD     = 4'd2,
      EV_RELEASED = 4'd3,
      EV_NOT_HELD = 4'd4,
      EV_ROLLOVER = 4'd5,
      EV_PAUSE    = 4'd6,
      EV_PROTO    = 4'd7,
      EV_SELFTEST = 4'd8,
      EV_READ     = 4'd9
   } event_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_step;
      logic commit;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic need_scan;
      logic scan_last;
   } dp_status_type;

   // expected byte in each pause state (bytes two to eight of E1 14 77 E1 F0 14 F0 77)
   function automatic logic [7:0] pause_expect(input logic [3:0] state);
      logic [7:0] result;
      case (state)
         4'd4:    result = BYTE_CTRL;
         4'd5:    result = BYTE_NUMLOCK;
         4'd6:    result = BYTE_PAUSE;
         4'd7:    result = BYTE_BREAK;
         4'd8:    result = BYTE_CTRL;
         4'd9:    result = BYTE_BREAK;
         4'd10:   result = BYTE_NUMLOCK;
         default: result = 8'h00;
      endcase
      return result;
   endfunction

endpackage

// File: design/scan_code_decoder_key_table_top.sv
// Scan code set 2 decoder with held-key table. One transaction at a time.
// An accepted transaction is latched, classified and, for a press or release of
// a nonzero key, put through a table scan of one slot per cycle; the result is
// committed once the output register is free. No new transaction until idle.
// Reset (synchronous, active high) empties the table, clears flags, idles decode.
// Depends on scd_pkg, scd_ctrl and scd_datapath.
module scan_code_decoder_key_table_top #(
   parameter int TABLE_SLOTS = scd_pkg::DEF_TABLE_SLOTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [7:0]                req_scan_byte,
   input  logic [2:0]                req_slot_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [3:0]                rsp_event_res,
   output logic [scd_pkg::KEY_W-1:0] rsp_key_code,
   output logic [scd_pkg::KEY_W-1:0] rsp_slot_key,
   output logic                      rsp_self_test_seen,
   output logic                      rsp_protocol_error,
   output logic                      rsp_pause_pressed,
   output logic                      rsp_rollover
);

   scd_pkg::ctrl_cmd_type  cmd;
   scd_pkg::dp_status_type status;

   scd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   scd_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_action),
      .req_scan_byte      (req_scan_byte),
      .req_slot_index     (req_slot_index),
      .rsp_event_res      (rsp_event_res),
      .rsp_key_code       (rsp_key_code),
      .rsp_slot_key       (rsp_slot_key),
      .rsp_self_test_seen (rsp_self_test_seen),
      .rsp_protocol_error (rsp_protocol_error),
      .rsp_pause_pressed  (rsp_pause_pressed),
      .rsp_rollover       (rsp_rollover)
   );

`ifndef SYNTH
   // busy right after taking a transaction
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted transaction did not make the block busy");

   // never overwrite a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && rsp_valid && rsp_stall))
      else $error("commit while result held by stall");

   // a rollover result always carries the rollover flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == scd_pkg::EV_ROLLOVER) |-> rsp_rollover)
      else $error("rollover event without rollover flag");

   // a commit makes a result valid in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit did not produce a result");
`endif

endmodule

// File: design/scd_ctrl.sv
// Controller state machine for the scan code decoder: sequences load,
// table scan and commit. Depends on scd_pkg for command and status structs.
module scd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  scd_pkg::dp_status_type status,
   output scd_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register can take a new result when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // decode commands from the current state
   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.scan_init = (state_ff == ST_CLASSIFY);
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.commit    = (state_ff == ST_FINISH) && out_free;
   end

   // next state and output valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            state_in = status.need_scan ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold state and registered valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/scd_datapath.sv
// Datapath for the scan code decoder: decode state, held-key table,
// scan trackers, sticky flags and result registers. Depends on scd_pkg.
module scd_datapath #(
   parameter int TABLE_SLOTS = scd_pkg::DEF_TABLE_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  scd_pkg::ctrl_cmd_type       cmd,
   output scd_pkg::dp_status_type      status,
   input  logic                        req_action,
   input  logic [7:0]                  req_scan_byte,
   input  logic [2:0]                  req_slot_index,
   output logic [3:0]                  rsp_event_res,
   output logic [scd_pkg::KEY_W-1:0]   rsp_key_code,
   output logic [scd_pkg::KEY_W-1:0]   rsp_slot_key,
   output logic                        rsp_self_test_seen,
   output logic                        rsp_protocol_error,
   output logic                        rsp_pause_pressed,
   output logic                        rsp_rollover
);

   localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int KW = scd_pkg::KEY_W;

   // latched transaction
   logic          action_ff;
   logic [7:0]    byte_ff;
   logic [2:0]    index_ff;

   logic [3:0]    decode_state_ff, decode_state_in;
   logic [KW-1:0] keys_ff [TABLE_SLOTS];
   logic [KW-1:0] keys_in [TABLE_SLOTS];
   logic [3:0]    flags_ff, flags_in;

   // scan trackers
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          match_found_ff, match_found_in;
   logic [AW-1:0] match_idx_ff, match_idx_in;
   logic          empty_found_ff, empty_found_in;
   logic [AW-1:0] empty_idx_ff, empty_idx_in;

   // result registers
   logic [3:0]    event_ff, event_in;
   logic [KW-1:0] key_out_ff, key_out_in;
   logic [KW-1:0] slot_ff, slot_in;

   // decode of the latched byte
   logic                 is_press;
   logic                 is_release;
   logic [KW-1:0]        key_code;
   logic [3:0]           ds_next;
   scd_pkg::event_type   ev_fixed;
   logic                 set_self;
   logic                 set_proto;
   logic                 set_pause;

   // table read port
   logic [31:0]   idx_wide;
   logic [AW-1:0] idx_addr;
   logic          idx_ok;
   logic [AW-1:0] rd_addr;
   logic [KW-1:0] rd_data;

   // commit decisions
   scd_pkg::event_type ev_final;
   logic               wr_en;
   logic [AW-1:0]      wr_idx;
   logic [KW-1:0]      wr_data;
   logic               clr_all;

   // classify the latched byte against the decode state
   always_comb begin
      is_press   = 1'b0;
      is_release = 1'b0;
      key_code   = '0;
      ds_next    = decode_state_ff;
      ev_fixed   = scd_pkg::EV_PREFIX;
      set_self   = 1'b0;
      set_proto  = 1'b0;
      set_pause  = 1'b0;
      if (action_ff) begin
         ev_fixed = scd_pkg::EV_READ;
      end else if (byte_ff == scd_pkg::BYTE_SELF_TEST) begin
         set_self = 1'b1;
         ev_fixed = scd_pkg::EV_SELFTEST;
      end else begin
         case (decode_state_ff)
            scd_pkg::DS_IDLE: begin
               if (byte_ff == scd_pkg::BYTE_BREAK) begin
                  ds_next = scd_pkg::DS_BRK;
               end else if (byte_ff == scd_pkg::BYTE_EXTEND) begin
                  ds_next = scd_pkg::DS_EXT;
               end else if (byte_ff == scd_pkg::BYTE_PAUSE) begin
                  ds_next = scd_pkg::DS_PAUSE_FIRST;
               end else begin
                  is_press = 1'b1;
                  key_code = {8'h00, byte_ff};
               end
            end
            scd_pkg::DS_EXT: begin
               if (byte_ff == scd_pkg::BYTE_BREAK) begin
                  ds_next = scd_pkg::DS_EXT_BRK;
               end else begin
                  is_press = 1'b1;
                  key_code = scd_pkg::EXT_KEY_BASE | {8'h00, byte_ff};
                  ds_next  = scd_pkg::DS_IDLE;
               end
            end
            scd_pkg::DS_BRK: begin
               is_release = 1'b1;
               key_code   = {8'h00, byte_ff};
               ds_next    = scd_pkg::DS_IDLE;
            end
            scd_pkg::DS_EXT_BRK: begin
               is_release = 1'b1;
               key_code   = scd_pkg::EXT_KEY_BASE | {8'h00, byte_ff};
               ds_next    = scd_pkg::DS_IDLE;
            end
            default: begin
               // pause sequence: check each byte in turn
               if (decode_state_ff >= scd_pkg::DS_PAUSE_FIRST &&
                   decode_state_ff <= scd_pkg::DS_PAUSE_LAST) begin
                  if (byte_ff != scd_pkg::pause_expect(decode_state_ff)) begin
                     set_proto = 1'b1;
                     ev_fixed  = scd_pkg::EV_PROTO;
                     ds_next   = scd_pkg::DS_IDLE;
                  end else if (decode_state_ff == scd_pkg::DS_PAUSE_LAST) begin
                     set_pause = 1'b1;
                     ev_fixed  = scd_pkg::EV_PAUSE;
                     ds_next   = scd_pkg::DS_IDLE;
                  end else begin
                     ds_next = decode_state_ff + 4'd1;
                  end
               end else begin
                  ds_next = scd_pkg::DS_IDLE;
               end
            end
         endcase
      end
   end

   assign status.need_scan = (is_press || is_release) && (key_code != '0);
   assign status.scan_last = (cnt_ff == AW'(TABLE_SLOTS - 1));

   // table read: scan counter while scanning, requested slot otherwise
   assign idx_wide = 32'(index_ff);
   assign idx_addr = idx_wide[AW-1:0];
   assign idx_ok   = (idx_wide < 32'(TABLE_SLOTS));
   assign rd_addr  = cmd.scan_step ? cnt_ff : idx_addr;
   assign rd_data  = keys_ff[rd_addr];

   // advance the scan, remember first match and first empty slot
   always_comb begin
      cnt_in         = cnt_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      if (cmd.scan_init) begin
         cnt_in         = '0;
         match_found_in = 1'b0;
         empty_found_in = 1'b0;
      end else if (cmd.scan_step) begin
         cnt_in = cnt_ff + AW'(1);
         if (!match_found_ff && rd_data == key_code) begin
            match_found_in = 1'b1;
            match_idx_in   = cnt_ff;
         end
         if (!empty_found_ff && rd_data == '0) begin
            empty_found_in = 1'b1;
            empty_idx_in   = cnt_ff;
         end
      end
   end

   // decide the table update and the event
   always_comb begin
      ev_final = ev_fixed;
      wr_en    = 1'b0;
      wr_idx   = match_idx_ff;
      wr_data  = '0;
      clr_all  = 1'b0;
      if (is_press) begin
         if (key_code == '0 || match_found_ff) begin
            ev_final = scd_pkg::EV_HELD;
         end else if (empty_found_ff) begin
            ev_final = scd_pkg::EV_ADDED;
            wr_en    = 1'b1;
            wr_idx   = empty_idx_ff;
            wr_data  = key_code;
         end else begin
            ev_final = scd_pkg::EV_ROLLOVER;
            clr_all  = 1'b1;
         end
      end else if (is_release) begin
         if (key_code != '0 && match_found_ff) begin
            ev_final = scd_pkg::EV_RELEASED;
            wr_en    = 1'b1;
            wr_idx   = match_idx_ff;
         end else begin
            ev_final = scd_pkg::EV_NOT_HELD;
         end
      end
   end

   // next table, flags, decode state and results on commit
   always_comb begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         keys_in[i] = keys_ff[i];
         if (cmd.commit) begin
            if (clr_all) begin
               keys_in[i] = '0;
            end else if (wr_en && wr_idx == AW'(i)) begin
               keys_in[i] = wr_data;
            end
         end
      end
      flags_in        = flags_ff;
      decode_state_in = decode_state_ff;
      event_in        = event_ff;
      key_out_in      = key_out_ff;
      slot_in         = slot_ff;
      if (cmd.commit) begin
         flags_in[scd_pkg::FLAG_SELF_TEST] = flags_ff[scd_pkg::FLAG_SELF_TEST] | set_self;
         flags_in[scd_pkg::FLAG_PROTO]     = flags_ff[scd_pkg::FLAG_PROTO] | set_proto;
         flags_in[scd_pkg::FLAG_PAUSE]     = flags_ff[scd_pkg::FLAG_PAUSE] | set_pause;
         flags_in[scd_pkg::FLAG_ROLLOVER]  = flags_ff[scd_pkg::FLAG_ROLLOVER] | clr_all;
         decode_state_in = ds_next;
         event_in        = ev_final;
         key_out_in      = key_code;
         slot_in         = (action_ff && idx_ok) ? rd_data : '0;
      end
   end

   // latch the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         byte_ff   <= req_scan_byte;
         index_ff  <= req_slot_index;
      end
   end

   // control state: table, flags, decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         decode_state_ff <= scd_pkg::DS_IDLE;
         flags_ff        <= '0;
         for (int i = 0; i < TABLE_SLOTS; i++) keys_ff[i] <= '0;
      end else begin
         decode_state_ff <= decode_state_in;
         flags_ff        <= flags_in;
         for (int i = 0; i < TABLE_SLOTS; i++) keys_ff[i] <= keys_in[i];
      end
   end

   // scan trackers and result payload
   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      event_ff       <= event_in;
      key_out_ff     <= key_out_in;
      slot_ff        <= slot_in;
   end

   assign rsp_event_res      = event_ff;
   assign rsp_key_code       = key_out_ff;
   assign rsp_slot_key       = slot_ff;
   assign rsp_self_test_seen = flags_ff[scd_pkg::FLAG_SELF_TEST];
   assign rsp_protocol_error = flags_ff[scd_pkg::FLAG_PROTO];
   assign rsp_pause_pressed  = flags_ff[scd_pkg::FLAG_PAUSE];
   assign rsp_rollover       = flags_ff[scd_pkg::FLAG_ROLLOVER];

endmodule
